// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the MIDI byte stream parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
    `ASSERT_AT(lbl, clk_s, rstn_s, !(expr))

`else

`define ASSERT_AT(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)

`endif

`endif

// ===== src/mbsp_pkg.sv =====
// Types, status codes and decode helpers of the MIDI byte stream parser.
package mbsp_pkg;

    // widths fixed by the result fields
    localparam int SX_IDX_W  = 6;
    localparam int BYTE_W    = 8;
    localparam int DATA_W    = 7;
    localparam int M_TDATA_W = 40;

    // MIDI status codes
    localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
    localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
    localparam logic [7:0] MSG_POLY_AT   = 8'hA0;
    localparam logic [7:0] MSG_CTRL      = 8'hB0;
    localparam logic [7:0] MSG_PROG      = 8'hC0;
    localparam logic [7:0] MSG_CHAN_AT   = 8'hD0;
    localparam logic [7:0] MSG_PITCH     = 8'hE0;
    localparam logic [7:0] MSG_SYSEX     = 8'hF0;
    localparam logic [7:0] MSG_MTC       = 8'hF1;
    localparam logic [7:0] MSG_SONG_POS  = 8'hF2;
    localparam logic [7:0] MSG_SONG_SEL  = 8'hF3;
    localparam logic [7:0] MSG_BUS_SEL   = 8'hF5;
    localparam logic [7:0] MSG_TUNE      = 8'hF6;
    localparam logic [7:0] MSG_EOX       = 8'hF7;
    localparam logic [7:0] MSG_CLOCK     = 8'hF8;
    localparam logic [7:0] MSG_START     = 8'hFA;
    localparam logic [7:0] MSG_CONT      = 8'hFB;
    localparam logic [7:0] MSG_STOP      = 8'hFC;
    localparam logic [7:0] MSG_SENSE     = 8'hFE;
    localparam logic [7:0] MSG_RESET     = 8'hFF;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_SYSEX = 2'd1,
        KIND_CLOCK = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_THREE,
        CLS_TWO,
        CLS_ONE,
        CLS_SYSEX
    } msg_class_t;

    // parser and drain sequencer states
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DATA1     = 7'b0000010,
        ST_DATA2     = 7'b0000100,
        ST_DATA_TWO  = 7'b0001000,
        ST_SYSEX     = 7'b0010000,
        ST_DRAIN_RD  = 7'b0100000,
        ST_DRAIN_OUT = 7'b1000000
    } state_t;

    // sysex store access, one write and one read port
    typedef struct packed {
        logic                wr_en;
        logic [SX_IDX_W-1:0] wr_addr;
        logic [BYTE_W-1:0]   wr_data;
        logic                rd_en;
        logic [SX_IDX_W-1:0] rd_addr;
    } mem_req_t;

    // message class of a status byte; channel nibble ignored below 0xF0
    function automatic msg_class_t classify(input logic [7:0] b);
        logic [7:0] cls;
        msg_class_t res;
        cls = (b < MSG_SYSEX) ? {b[7:4], 4'h0} : b;
        unique case (cls) inside
            MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_AT, MSG_CTRL, MSG_PITCH,
            MSG_SONG_POS:
                res = CLS_THREE;
            MSG_PROG, MSG_CHAN_AT, MSG_MTC, MSG_SONG_SEL, MSG_BUS_SEL:
                res = CLS_TWO;
            MSG_TUNE, MSG_START, MSG_CONT, MSG_STOP, MSG_SENSE, MSG_RESET:
                res = CLS_ONE;
            MSG_SYSEX:
                res = CLS_SYSEX;
            default:
                res = CLS_NONE;
        endcase
        return res;
    endfunction

endpackage

// ===== src/mbsp_sysex_mem.sv =====
// Sysex byte store: one write port, one read port with registered data.
module mbsp_sysex_mem
    import mbsp_pkg::*;
#(
    parameter int SYSEX_BYTES = 64
)
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rd_data
);

    localparam int AW = (SYSEX_BYTES > 1) ? $clog2(SYSEX_BYTES) : 1;

    logic [BYTE_W-1:0] mem [SYSEX_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/midi_byte_stream_parser_unit.sv =====
// Top level of the MIDI byte stream parser: byte parsing, sysex drain, output register.
//
//  channel | dir | transfer                     | payload
//  --------+-----+------------------------------+-------------------------------------
//  s_*     | in  | one received MIDI byte       | s_tdata: rx_byte
//  m_*     | out | one parsed message or a byte | m_tuser: kind, m_tlast: last,
//          |     | of a stored sysex message    | m_tdata: status..sysex_index
//
// Flow: a received byte is taken whenever the output register is free or being
// emptied and no drain runs. An end-of-exclusive byte starts a drain of the sysex
// store, each stored byte read from memory and then loaded into the output
// register; s_tready stays low until the drain ends.
// Reset: rst_n clears the parser state and the output valid; the sysex store
// is not cleared, only entries written during the current message are read.
// Stalls: m_tready low holds the output register; a byte is then taken only if
// the register is empty.
`include "assert_macros.svh"

module midi_byte_stream_parser_unit
    import mbsp_pkg::*;
#(
    parameter int SYSEX_BYTES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] status_byte, [14:8] first_data,
                                            // [21:15] second_data, [29:22] sysex_byte,
                                            // [35:30] sysex_index, [39:36] zero
    output logic [1:0]           m_tuser,   // [1:0] kind
    output logic                 m_tlast    // last
);

    localparam int AW = (SYSEX_BYTES > 1) ? $clog2(SYSEX_BYTES) : 1;
    localparam int FW = $clog2(SYSEX_BYTES + 1);
    localparam logic [FW-1:0] FILL_START = FW'(1);
    localparam logic [FW-1:0] FILL_MAX   = FW'(SYSEX_BYTES);

    // parser state
    state_t              state_reg, state_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [BYTE_W-1:0]   held_status_reg, held_status_next;
    logic [DATA_W-1:0]   held_first_reg, held_first_next;
    // drain sequencer
    logic [AW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0]       last_idx_reg, last_idx_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]   out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_first_reg, out_first_next;
    logic [DATA_W-1:0]   out_second_reg, out_second_next;
    logic [BYTE_W-1:0]   out_sx_reg, out_sx_next;
    logic [SX_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                out_last_reg, out_last_next;

    mem_req_t            mem_req;
    logic [BYTE_W-1:0]   mem_rd_data;

    logic                out_free;
    logic                in_phase;
    logic                accept;
    logic                load;
    logic                drain_done;
    logic [7:0]          b;

    mbsp_sysex_mem #(
        .SYSEX_BYTES (SYSEX_BYTES)
    ) u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign in_phase = (state_reg == ST_IDLE) || (state_reg == ST_DATA1) ||
                      (state_reg == ST_DATA2) || (state_reg == ST_DATA_TWO) ||
                      (state_reg == ST_SYSEX);
    assign s_tready = out_free && in_phase;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        held_status_next = held_status_reg;
        held_first_next  = held_first_reg;
        rd_cnt_next      = rd_cnt_reg;
        last_idx_next    = last_idx_reg;
        load             = 1'b0;
        drain_done       = 1'b0;
        out_kind_next    = KIND_SHORT;
        out_status_next  = '0;
        out_first_next   = '0;
        out_second_next  = '0;
        out_sx_next      = '0;
        out_idx_next     = '0;
        out_last_next    = 1'b1;
        mem_req          = '0;

        if (accept && (b == MSG_CLOCK))
        begin
            // clock tick passes through any phase untouched
            load            = 1'b1;
            out_kind_next   = KIND_CLOCK;
            out_status_next = MSG_CLOCK;
        end
        else
        begin
            unique case (state_reg) inside
                ST_IDLE:
                begin
                    if (accept && b[7])
                    begin
                        held_status_next = b;
                        held_first_next  = '0;
                        case (classify(b))
                            CLS_THREE: state_next = ST_DATA1;
                            CLS_TWO:   state_next = ST_DATA_TWO;
                            CLS_ONE:
                            begin
                                load            = 1'b1;
                                out_status_next = b;
                            end
                            CLS_SYSEX:
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = '0;
                                mem_req.wr_data = MSG_SYSEX;
                                fill_next       = FILL_START;
                                state_next      = ST_SYSEX;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DATA1:
                begin
                    if (accept)
                    begin
                        if (b[7])
                        begin
                            state_next = ST_IDLE;
                            fill_next  = FILL_START;
                        end
                        else
                        begin
                            held_first_next = b[DATA_W-1:0];
                            state_next      = ST_DATA2;
                        end
                    end
                end
                ST_DATA2, ST_DATA_TWO:
                begin
                    if (accept)
                    begin
                        state_next = ST_IDLE;
                        fill_next  = FILL_START;
                        if (!b[7])
                        begin
                            load            = 1'b1;
                            out_status_next = held_status_reg;
                            if (state_reg == ST_DATA2)
                            begin
                                out_first_next  = held_first_reg;
                                out_second_next = b[DATA_W-1:0];
                            end
                            else
                            begin
                                out_first_next = b[DATA_W-1:0];
                            end
                        end
                    end
                end
                ST_SYSEX:
                begin
                    if (accept)
                    begin
                        if (fill_reg >= FILL_MAX)
                        begin
                            // overflow: message and byte dropped
                            state_next = ST_IDLE;
                            fill_next  = FILL_START;
                        end
                        else if (b == MSG_EOX)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = SX_IDX_W'(fill_reg);
                            mem_req.wr_data = b;
                            last_idx_next   = AW'(fill_reg);
                            rd_cnt_next     = '0;
                            state_next      = ST_DRAIN_RD;
                        end
                        else if (b[7])
                        begin
                            state_next = ST_IDLE;
                            fill_next  = FILL_START;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = SX_IDX_W'(fill_reg);
                            mem_req.wr_data = b;
                            fill_next       = fill_reg + FW'(1);
                        end
                    end
                end
                ST_DRAIN_RD:
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = SX_IDX_W'(rd_cnt_reg);
                    state_next      = ST_DRAIN_OUT;
                end
                ST_DRAIN_OUT:
                begin
                    // read data stays in the memory's output register while stalled
                    if (out_free)
                    begin
                        load            = 1'b1;
                        out_kind_next   = KIND_SYSEX;
                        out_status_next = MSG_SYSEX;
                        out_sx_next     = mem_rd_data;
                        out_idx_next    = SX_IDX_W'(rd_cnt_reg);
                        out_last_next   = (rd_cnt_reg == last_idx_reg);
                        if (rd_cnt_reg == last_idx_reg)
                        begin
                            drain_done = 1'b1;
                            state_next = ST_IDLE;
                            fill_next  = FILL_START;
                        end
                        else
                        begin
                            rd_cnt_next = rd_cnt_reg + AW'(1);
                            state_next  = ST_DRAIN_RD;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    fill_next  = FILL_START;
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= FILL_START;
            held_status_reg <= '0;
            held_first_reg  <= '0;
            rd_cnt_reg      <= '0;
            last_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            held_status_reg <= held_status_next;
            held_first_reg  <= held_first_next;
            rd_cnt_reg      <= rd_cnt_next;
            last_idx_reg    <= last_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, loaded together with the valid
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_sx_reg     <= out_sx_next;
            out_idx_reg    <= out_idx_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'h0, out_idx_reg, out_sx_reg, out_second_reg,
                       out_first_reg, out_status_reg};

    // drain never reads past the end-of-exclusive entry
    `ASSERT_AT(a_drain_in_range, clk, rst_n,
        (state_reg == ST_DRAIN_RD || state_reg == ST_DRAIN_OUT) |->
            (rd_cnt_reg <= last_idx_reg))

    // final drained byte hands the parser back to idle
    `ASSERT_AT(a_drain_ends_idle, clk, rst_n,
        drain_done |=> (state_reg == ST_IDLE && fill_reg == FILL_START))

    // store writes stay inside the memory
    `ASSERT_NEVER(a_wr_in_range, clk, rst_n,
        mem_req.wr_en && ({1'b0, mem_req.wr_addr} >= (SX_IDX_W + 1)'(SYSEX_BYTES)))

    // a sysex run always opens with the start-of-exclusive byte
    `ASSERT_AT(a_sysex_head, clk, rst_n,
        (m_tvalid && out_kind_reg == KIND_SYSEX && out_idx_reg == '0) |->
            (out_sx_reg == MSG_SYSEX))

endmodule

// ===== dv/midi_byte_stream_parser_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the MIDI byte stream parser: directed table, then random messages.
module midi_byte_stream_parser_unit_test;
    import mbsp_pkg::*;

    localparam int SYSEX_BYTES  = 64;
    localparam int RANDOM_ITEMS = 330;
    localparam int N_DIRECTED   = 25;
    localparam int LONG_HOLD    = 300;      // receiver hold-off, in cycles
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 2 * SYSEX_BYTES + 16;
    localparam int MAX_REPORTS  = 10;

    // status bytes with no meaning for the parser
    localparam logic [7:0] MSG_UNDEF_F4 = 8'hF4;
    localparam logic [7:0] MSG_UNDEF_F9 = 8'hF9;
    localparam logic [7:0] MSG_UNDEF_FD = 8'hFD;

    // how a stimulus row is checked: by the parser model, or by a typed-in answer
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,   // typed: no result
        CHK_ONE     // typed: exactly one result
    } row_check_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DATA1,
        PH_DATA2,
        PH_DATA_ONLY,
        PH_SYSEX
    } parse_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic [7:0] sx_byte;
        logic [5:0] sx_idx;
        logic       last;
    } midi_result_t;

    typedef struct packed {
        logic [7:0] rx;
        row_check_t chk;
        kind_t      kind;
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
    } stim_row_t;

    // Directed part: idle data, clock mid-message, unknown status, aborts,
    // stray data, a short sysex, one-byte messages and the field extremes.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},             // data while idle
        '{8'h7F, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{MSG_CLOCK, CHK_ONE, KIND_CLOCK, MSG_CLOCK, 7'h00, 7'h00},
        '{MSG_NOTE_ON, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{8'h00, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{8'h7F, CHK_ONE, KIND_SHORT, MSG_NOTE_ON, 7'h00, 7'h7F},
        '{MSG_UNDEF_F4, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},      // unknown status
        '{MSG_NOTE_OFF | 8'h0F, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{8'h7F, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{MSG_CLOCK, CHK_ONE, KIND_CLOCK, MSG_CLOCK, 7'h00, 7'h00},      // clock mid-message
        '{8'h00, CHK_ONE, KIND_SHORT, MSG_NOTE_OFF | 8'h0F, 7'h7F, 7'h00},
        '{MSG_PROG | 8'h03, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{8'h45, CHK_ONE, KIND_SHORT, MSG_PROG | 8'h03, 7'h45, 7'h00},
        '{MSG_RESET, CHK_ONE, KIND_SHORT, MSG_RESET, 7'h00, 7'h00},
        '{MSG_PITCH, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{MSG_NOTE_ON, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},       // aborts, dropped
        '{8'h10, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},             // stray data
        '{MSG_SYSEX, CHK_PRED, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{8'h00, CHK_PRED, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{8'h7F, CHK_PRED, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{MSG_EOX, CHK_PRED, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{MSG_CHAN_AT, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},
        '{MSG_TUNE, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00},          // aborts, dropped
        '{MSG_TUNE, CHK_ONE, KIND_SHORT, MSG_TUNE, 7'h00, 7'h00},
        '{MSG_UNDEF_FD, CHK_NONE, KIND_SHORT, 8'h00, 7'h00, 7'h00}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    // travel with s_tdata so the monitor sees the row that belongs to the transfer
    row_check_t   row_chk = CHK_PRED;
    midi_result_t row_want = '0;

    // parser model state
    parse_phase_t parse_ph = PH_IDLE;
    int           sx_fill = 1;
    logic [7:0]   cur_status = 8'h00;
    logic [6:0]   cur_data1 = 7'h00;
    logic [7:0]   sx_buf [SYSEX_BYTES];
    midi_result_t parsed_due [$];   // messages the parser owes, oldest first

    int mismatches = 0;
    int cycles = 0;
    int fed_count = 0;
    bit long_hold = 1'b0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    midi_byte_stream_parser_unit #(
        .SYSEX_BYTES(SYSEX_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #10 clk = ~clk;

    // Run limit: a hung handshake ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void queue_result(input kind_t kind, input logic [7:0] st,
                                         input logic [6:0] d1, input logic [6:0] d2,
                                         input logic [7:0] sx, input logic [5:0] idx,
                                         input logic fin);
        midi_result_t r;
        r.kind    = kind;
        r.status  = st;
        r.data1   = d1;
        r.data2   = d2;
        r.sx_byte = sx;
        r.sx_idx  = idx;
        r.last    = fin;
        parsed_due.push_back(r);
    endfunction

    function automatic void drop_to_idle();
        parse_ph = PH_IDLE;
        sx_fill  = 1;
    endfunction

    // Parser model: one received byte in, the messages it completes queued.
    function automatic void parse_midi_byte(input logic [7:0] b);
        logic [7:0] grp;
        // timing clock passes through in any phase and touches no state
        if (b == MSG_CLOCK)
        begin
            queue_result(KIND_CLOCK, MSG_CLOCK, 7'h00, 7'h00, 8'h00, 6'h00, 1'b1);
            return;
        end
        case (parse_ph)
            PH_IDLE:
                if (b[7])
                begin
                    cur_status = b;
                    cur_data1  = 7'h00;
                    grp = (b < MSG_SYSEX) ? {b[7:4], 4'h0} : b;
                    case (grp)
                        MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_AT, MSG_CTRL, MSG_PITCH,
                        MSG_SONG_POS:
                            parse_ph = PH_DATA1;
                        MSG_PROG, MSG_CHAN_AT, MSG_MTC, MSG_SONG_SEL, MSG_BUS_SEL:
                            parse_ph = PH_DATA_ONLY;
                        MSG_TUNE, MSG_START, MSG_CONT, MSG_STOP, MSG_SENSE, MSG_RESET:
                            queue_result(KIND_SHORT, b, 7'h00, 7'h00, 8'h00, 6'h00, 1'b1);
                        MSG_SYSEX:
                        begin
                            sx_buf[0] = MSG_SYSEX;
                            sx_fill   = 1;
                            parse_ph  = PH_SYSEX;
                        end
                        default:
                            ;   // unknown status ignored
                    endcase
                end
            PH_DATA1:
                if (b[7])
                    drop_to_idle();
                else
                begin
                    cur_data1 = b[6:0];
                    parse_ph  = PH_DATA2;
                end
            PH_DATA2:
            begin
                if (!b[7])
                    queue_result(KIND_SHORT, cur_status, cur_data1, b[6:0], 8'h00, 6'h00,
                                 1'b1);
                drop_to_idle();
            end
            PH_DATA_ONLY:
            begin
                if (!b[7])
                    queue_result(KIND_SHORT, cur_status, b[6:0], 7'h00, 8'h00, 6'h00, 1'b1);
                drop_to_idle();
            end
            PH_SYSEX:
                if (sx_fill >= SYSEX_BYTES)
                    drop_to_idle();     // store full: whole message lost
                else if (b == MSG_EOX)
                begin
                    sx_buf[sx_fill] = b;
                    for (int k = 0; k <= sx_fill; k++)
                        queue_result(KIND_SYSEX, MSG_SYSEX, 7'h00, 7'h00, sx_buf[k], 6'(k),
                                     k == sx_fill);
                    drop_to_idle();
                end
                else if (b[7])
                    drop_to_idle();
                else
                begin
                    sx_buf[sx_fill] = b;
                    sx_fill++;
                end
            default:
                drop_to_idle();
        endcase
    endfunction

    // Monitor: input transfers feed the model, output transfers are checked
    // against the oldest owed message. Values are the ones before the edge.
    always @(posedge clk)
    begin
        int           n_before;
        midi_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                n_before = parsed_due.size();
                parse_midi_byte(s_tdata);
                // typed rows replace the model's answer, the model state still moves
                if (row_chk != CHK_PRED)
                begin
                    while (parsed_due.size() > n_before)
                        void'(parsed_due.pop_back());
                    if (row_chk == CHK_ONE)
                        parsed_due.push_back(row_want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (parsed_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: kind %0d tdata %h last %0b",
                                 m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = parsed_due.pop_front();
                    if (m_tuser !== want.kind || m_tdata[7:0] !== want.status ||
                        m_tdata[14:8] !== want.data1 || m_tdata[21:15] !== want.data2 ||
                        m_tdata[29:22] !== want.sx_byte || m_tdata[35:30] !== want.sx_idx ||
                        m_tdata[M_TDATA_W-1:36] !== '0 || m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result mismatch: expected kind %0d st %h d %h %h ",
                                      "sx %h @%0d last %0b / got kind %0d tdata %h last %0b"},
                                     want.kind, want.status, want.data1, want.data2,
                                     want.sx_byte, want.sx_idx, want.last,
                                     m_tuser, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // Receiver: a random gap before each transfer, gap-free stretches, and one
    // long hold-off on request so the output and then the input back up.
    initial
    begin
        int gap;
        wait (rst_n == 1'b1);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_steady = ~rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // One byte transfer; valid stays high into the next byte when no gap is drawn.
    task automatic send_byte(input logic [7:0] b, input row_check_t chk,
                             input midi_result_t want);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        row_chk  <= chk;
        row_want <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Sender pause until every owed message has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (parsed_due.size() != 0)
            @(posedge clk);
    endtask

    // Sends a message, now and then with a timing clock slipped in before a byte.
    task automatic feed_bytes(input logic [7:0] msg [$], input bit counted);
        foreach (msg[i])
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_byte(MSG_CLOCK, CHK_PRED, '0);
                fed_count++;
            end
            send_byte(msg[i], CHK_PRED, '0);
            if (counted)
                fed_count++;
        end
    endtask

    function automatic logic [7:0] pick_status(input bit three);
        logic [7:0] st;
        if (three)
            case ($urandom_range(0, 5))
                0:       st = MSG_NOTE_OFF;
                1:       st = MSG_NOTE_ON;
                2:       st = MSG_POLY_AT;
                3:       st = MSG_CTRL;
                4:       st = MSG_PITCH;
                default: st = MSG_SONG_POS;
            endcase
        else
            case ($urandom_range(0, 4))
                0:       st = MSG_PROG;
                1:       st = MSG_CHAN_AT;
                2:       st = MSG_MTC;
                3:       st = MSG_SONG_SEL;
                default: st = MSG_BUS_SEL;
            endcase
        if (st < MSG_SYSEX)
            st[3:0] = 4'($urandom_range(0, 15));
        return st;
    endfunction

    // Sysex with n data bytes, closed by end-of-exclusive or cut by a status byte.
    task automatic send_sysex(input int n, input bit cut);
        logic [7:0] msg [$];
        msg.push_back(MSG_SYSEX);
        repeat (n)
            msg.push_back(8'($urandom_range(0, 127)));
        msg.push_back(cut ? 8'($urandom_range(128, 255)) : MSG_EOX);
        feed_bytes(msg, 1'b1);
    endtask

    // Mostly well-formed messages with random content; some broken ones and noise.
    task automatic send_random_message();
        logic [7:0] msg [$];
        int         pick;
        int         n;
        bit         three;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            msg.push_back(pick_status(1'b1));
            msg.push_back(8'($urandom_range(0, 127)));
            msg.push_back(8'($urandom_range(0, 127)));
            feed_bytes(msg, 1'b1);
        end
        else if (pick < 50)
        begin
            msg.push_back(pick_status(1'b0));
            msg.push_back(8'($urandom_range(0, 127)));
            feed_bytes(msg, 1'b1);
        end
        else if (pick < 60)
        begin
            case ($urandom_range(0, 5))
                0:       msg.push_back(MSG_TUNE);
                1:       msg.push_back(MSG_START);
                2:       msg.push_back(MSG_CONT);
                3:       msg.push_back(MSG_STOP);
                4:       msg.push_back(MSG_SENSE);
                default: msg.push_back(MSG_RESET);
            endcase
            feed_bytes(msg, 1'b1);
        end
        else if (pick < 78)
        begin
            // mostly short; now and then near or past the store depth
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(56, SYSEX_BYTES - 1)
                                            : $urandom_range(0, 8);
            send_sysex(n, $urandom_range(0, 7) == 0);
        end
        else if (pick < 88)
        begin
            // message cut short by a status byte
            three = 1'($urandom_range(0, 1));
            msg.push_back(pick_status(three));
            if (three && $urandom_range(0, 1) == 1)
                msg.push_back(8'($urandom_range(0, 127)));
            msg.push_back(8'($urandom_range(128, 255)));
            feed_bytes(msg, 1'b1);
        end
        else if (pick < 94)
        begin
            msg.push_back(MSG_CLOCK);
            feed_bytes(msg, 1'b1);
        end
        else
        begin
            // noise: random bytes and undefined status codes, not counted
            repeat ($urandom_range(1, 3))
                if ($urandom_range(0, 1) == 1)
                    msg.push_back(8'($urandom_range(0, 255)));
                else
                    case ($urandom_range(0, 3))
                        0:       msg.push_back(MSG_UNDEF_F4);
                        1:       msg.push_back(MSG_UNDEF_F9);
                        2:       msg.push_back(MSG_UNDEF_FD);
                        default: msg.push_back(MSG_EOX);
                    endcase
            feed_bytes(msg, 1'b0);
        end
    endtask

    // Stimulus: reset, directed table, then random messages.
    initial
    begin
        stim_row_t    r;
        midi_result_t want;
        logic [7:0]   one_byte [$];
        int           msg_no;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            r = DIRECTED_ROWS[i];
            want = '0;
            want.kind   = r.kind;
            want.status = r.status;
            want.data1  = r.data1;
            want.data2  = r.data2;
            want.last   = 1'b1;
            send_byte(r.rx, r.chk, want);
        end
        wait_drained();

        fed_count = 0;
        msg_no = 0;
        one_byte.push_back(MSG_START);
        while (fed_count < RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 5) == 0);
            if (msg_no == 4)
            begin
                // receiver goes quiet after the next transfer; a full-depth sysex
                // and back-to-back bytes then pile up behind it
                long_hold = 1'b1;
                tx_steady = 1'b1;
                feed_bytes(one_byte, 1'b1);
                send_sysex(SYSEX_BYTES - 2, 1'b0);
            end
            else if (msg_no == 12)
                send_sysex(SYSEX_BYTES - 1, 1'b0);  // one byte past the store: dropped
            else if (msg_no % 25 == 24)
            begin
                wait_drained();
                send_random_message();
            end
            else
                send_random_message();
            msg_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/mbsp_pkg.sv
src/mbsp_sysex_mem.sv
src/midi_byte_stream_parser_unit.sv
dv/midi_byte_stream_parser_unit_test.sv
